// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the projection block.
// Each macro expands to one labeled concurrent assertion on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define AWTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define AWTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/awts_pkg.sv
// Shared types, widths and constants of the angular world-to-screen projection.
// Used by the CORDIC and top-level files; depends on nothing.
package awts_pkg;

    // Width of the CORDIC datapath (x, y and angle accumulator).
    localparam int CW = 36;
    // Width of the quotient path of the rounding dividers.
    localparam int DIV_W = 50;
    // Width of the divisor of the rounding dividers.
    localparam int DEN_W = 28;

    // Angles in radians, Q30.
    localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;

    // Register reset values.
    localparam logic [15:0] LOOK_X_RST = 16'd32767;
    localparam logic [14:0] FOV_RST    = 15'd12868;
    localparam logic [15:0] ASPECT_RST = 16'd5461;

    typedef enum logic [2:0] {
        CFG_CAM_POS_X  = 3'd0,
        CFG_CAM_POS_Y  = 3'd1,
        CFG_CAM_POS_Z  = 3'd2,
        CFG_LOOK_DIR_X = 3'd3,
        CFG_LOOK_DIR_Y = 3'd4,
        CFG_LOOK_DIR_Z = 3'd5,
        CFG_HORIZ_FOV  = 3'd6,
        CFG_ASPECT     = 3'd7
    } cfg_reg_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] ang;
        unique case (idx)
            5'd0:  ang = 36'sd843314856;
            5'd1:  ang = 36'sd497837829;
            5'd2:  ang = 36'sd263043836;
            5'd3:  ang = 36'sd133525158;
            5'd4:  ang = 36'sd66958198;
            5'd5:  ang = 36'sd33543515;
            5'd6:  ang = 36'sd16777898;
            5'd7:  ang = 36'sd8388437;
            5'd8:  ang = 36'sd4194282;
            5'd9:  ang = 36'sd2097149;
            5'd10: ang = 36'sd1048575;
            5'd11: ang = 36'sd524287;
            5'd12: ang = 36'sd262143;
            5'd13: ang = 36'sd131071;
            5'd14: ang = 36'sd65535;
            5'd15: ang = 36'sd32767;
            5'd16: ang = 36'sd16383;
            5'd17: ang = 36'sd8191;
            5'd18: ang = 36'sd4095;
            5'd19: ang = 36'sd2047;
            5'd20: ang = 36'sd1023;
            5'd21: ang = 36'sd511;
            5'd22: ang = 36'sd255;
            5'd23: ang = 36'sd127;
            5'd24: ang = 36'sd63;
            5'd25: ang = 36'sd31;
            5'd26: ang = 36'sd15;
            5'd27: ang = 36'sd8;
            5'd28: ang = 36'sd4;
            5'd29: ang = 36'sd2;
            5'd30: ang = 36'sd1;
            5'd31: ang = 36'sd0;
        endcase
        return ang;
    endfunction

endpackage

// File: rtl/awts_delay.sv
// Enabled shift-register delay line used to align side paths with the main pipeline.
// Stand-alone; no package dependency.
module awts_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dly_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dly_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[DEPTH-1];

endmodule

// File: rtl/awts_isqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Stand-alone; no package dependency.
module awts_isqrt #(
    parameter int IW = 64
) (
    input  logic            clk,
    input  logic            en,
    input  logic [IW-1:0]   n_in,
    output logic [IW/2-1:0] root
);

    localparam int NS = IW / 2;

    logic [IW-1:0] n_reg   [NS];
    logic [IW-1:0] res_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam logic [IW:0] BIT = (IW+1)'(1) << (IW - 2 - 2 * k);
        logic [IW-1:0] n_cur;
        logic [IW-1:0] res_cur;
        logic [IW:0]   trial;
        logic          ge;
        logic [IW-1:0] n_next;
        logic [IW-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign n_cur   = n_in;
            assign res_cur = '0;
        end
        else
        begin : g_rest
            assign n_cur   = n_reg[k-1];
            assign res_cur = res_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, res_cur} + BIT;
            ge    = ({1'b0, n_cur} >= trial);
            if (ge)
            begin
                n_next   = IW'({1'b0, n_cur} - trial);
                res_next = IW'(({1'b0, res_cur} >> 1) + BIT);
            end
            else
            begin
                n_next   = n_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[NS-1][NS-1:0];

endmodule

// File: rtl/awts_cordic.sv
// Pipelined vectoring CORDIC that returns atan2(y, x) in Q30 radians.
// Uses awts_pkg for the datapath width, pi/2 and the arctangent table.
module awts_cordic #(
    parameter int STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic signed [awts_pkg::CW-1:0] x_in,
    input  logic signed [awts_pkg::CW-1:0] y_in,
    output logic signed [awts_pkg::CW-1:0] z_out
);

    localparam int CW = awts_pkg::CW;

    logic signed [CW-1:0] x_reg [STAGES+1];
    logic signed [CW-1:0] y_reg [STAGES+1];
    logic signed [CW-1:0] z_reg [STAGES+1];
    logic                 zero_reg [STAGES+1];

    logic signed [CW-1:0] x0_next;
    logic signed [CW-1:0] y0_next;
    logic signed [CW-1:0] z0_next;

    // Vectors in the left half-plane are first turned by a quarter turn.
    always_comb
    begin
        if (x_in[CW-1])
        begin
            if (!y_in[CW-1])
            begin
                x0_next = y_in;
                y0_next = -x_in;
                z0_next = awts_pkg::Q30_HALF_PI;
            end
            else
            begin
                x0_next = -y_in;
                y0_next = x_in;
                z0_next = -awts_pkg::Q30_HALF_PI;
            end
        end
        else
        begin
            x0_next = x_in;
            y0_next = y_in;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [CW-1:0] ANG = awts_pkg::atan_q30(5'(i));
        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;

        assign x_sh = x_reg[i] >>> i;
        assign y_sh = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                zero_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + y_sh;
                    y_reg[i+1] <= y_reg[i] - x_sh;
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - y_sh;
                    y_reg[i+1] <= y_reg[i] + x_sh;
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign z_out = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

// File: rtl/awts_div.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Stand-alone; the divisor must be nonzero and steady.
module awts_div #(
    parameter int NW = 50,
    parameter int DW = 28
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    // Each stage shifts one dividend bit into the remainder and one quotient bit in.
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] rem_reg [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [NW-1:0] num_cur;
        logic [DW-1:0] rem_cur;
        logic [DW:0]   part;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] num_next;

        if (i == 0)
        begin : g_first
            assign num_cur = num;
            assign rem_cur = '0;
        end
        else
        begin : g_rest
            assign num_cur = num_reg[i-1];
            assign rem_cur = rem_reg[i-1];
        end

        always_comb
        begin
            part     = {rem_cur, num_cur[NW-1]};
            ge       = (part >= {1'b0, den});
            rem_next = ge ? DW'(part - {1'b0, den}) : part[DW-1:0];
            num_next = {num_cur[NW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i] <= num_next;
                rem_reg[i] <= rem_next;
            end
        end
    end

    assign quo = num_reg[NW-1];

endmodule

// File: rtl/angular_world_to_screen.sv
// Angular world-to-screen projection: top level with configuration registers and pipeline.
// Uses awts_pkg, awts_delay, awts_isqrt, awts_cordic and awts_div.
// Throughput: one word per cycle while not stalled; the depth is set by the 32-step square root
// of the horizontal sum in series with the pitch CORDIC and the 50-step dividers. The whole
// pipeline holds while the output register keeps a word that is not yet taken. Reset clears all
// valid flags and loads the configuration defaults; there is no clearing pass.
module angular_world_to_screen #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] obj_x,
    input  logic signed [31:0] obj_y,
    input  logic signed [31:0] obj_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic [31:0]        distance
);

    localparam int CW      = awts_pkg::CW;
    localparam int DIV_W   = awts_pkg::DIV_W;
    localparam int DEN_W   = awts_pkg::DEN_W;
    localparam int CL      = CORDIC_STAGES + 1;
    localparam int SQ64_L  = 32;
    localparam int SQ32_L  = 16;

    // Register stage at which each value becomes available.
    localparam int ST_DIFF  = 1;
    localparam int ST_TS    = 4;
    localparam int ST_SQRT  = ST_TS + SQ64_L;
    localparam int ST_YAW   = ST_DIFF + CL;
    localparam int ST_RELY  = ST_YAW + 1;
    localparam int ST_PITCH = ST_SQRT + CL;
    localparam int ST_RELP  = ST_PITCH + 1;
    localparam int ST_PROD  = ST_RELP + 1;
    localparam int ST_NUM   = ST_PROD + 1;
    localparam int ST_QUOT  = ST_NUM + DIV_W;

    // Configuration registers.
    logic signed [31:0] cam_pos_x_reg;
    logic signed [31:0] cam_pos_y_reg;
    logic signed [31:0] cam_pos_z_reg;
    logic signed [15:0] look_dir_x_reg;
    logic signed [15:0] look_dir_y_reg;
    logic signed [15:0] look_dir_z_reg;
    logic [14:0]        horiz_fov_reg;
    logic [15:0]        aspect_ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_x_reg    <= '0;
            cam_pos_y_reg    <= '0;
            cam_pos_z_reg    <= '0;
            look_dir_x_reg   <= awts_pkg::LOOK_X_RST;
            look_dir_y_reg   <= '0;
            look_dir_z_reg   <= '0;
            horiz_fov_reg    <= awts_pkg::FOV_RST;
            aspect_ratio_reg <= awts_pkg::ASPECT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (awts_pkg::cfg_reg_t'(cfg_index))
                awts_pkg::CFG_CAM_POS_X:  cam_pos_x_reg    <= cfg_wr_data;
                awts_pkg::CFG_CAM_POS_Y:  cam_pos_y_reg    <= cfg_wr_data;
                awts_pkg::CFG_CAM_POS_Z:  cam_pos_z_reg    <= cfg_wr_data;
                awts_pkg::CFG_LOOK_DIR_X: look_dir_x_reg   <= cfg_wr_data[15:0];
                awts_pkg::CFG_LOOK_DIR_Y: look_dir_y_reg   <= cfg_wr_data[15:0];
                awts_pkg::CFG_LOOK_DIR_Z: look_dir_z_reg   <= cfg_wr_data[15:0];
                awts_pkg::CFG_HORIZ_FOV:  horiz_fov_reg    <= cfg_wr_data[14:0];
                awts_pkg::CFG_ASPECT:     aspect_ratio_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // A zero fov acts as the smallest step.
    logic [14:0]      fov_eff;
    logic [DEN_W-1:0] den_yaw;
    logic [DEN_W-1:0] den_pitch;

    assign fov_eff   = (horiz_fov_reg == '0) ? 15'd1 : horiz_fov_reg;
    assign den_yaw   = {12'b0, fov_eff, 1'b0};
    assign den_pitch = {fov_eff, 13'b0};

    // The pipeline moves as a whole unless the output word is held.
    logic out_valid_reg;
    logic en;

    assign in_stall = out_valid_reg && out_stall;
    assign en       = !in_stall;

    // Stage 1: camera-to-object difference and camera pitch argument.
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [32:0] dz_reg;
    logic signed [15:0] lx_reg;
    logic signed [15:0] ly_reg;
    logic signed [15:0] lz_reg;
    logic [31:0]        carg_reg;
    logic signed [31:0] lz_sq;

    assign lz_sq = look_dir_z_reg * look_dir_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= {obj_x[31], obj_x} - {cam_pos_x_reg[31], cam_pos_x_reg};
            dy_reg   <= {obj_y[31], obj_y} - {cam_pos_y_reg[31], cam_pos_y_reg};
            dz_reg   <= {obj_z[31], obj_z} - {cam_pos_z_reg[31], cam_pos_z_reg};
            lx_reg   <= look_dir_x_reg;
            ly_reg   <= look_dir_y_reg;
            lz_reg   <= look_dir_z_reg;
            carg_reg <= 32'h4000_0000 - lz_sq;
        end
    end

    // Stage 2: magnitudes and their squares, plus squares of the halved magnitudes.
    logic signed [32:0] dx_neg;
    logic signed [32:0] dy_neg;
    logic signed [32:0] dz_neg;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        az;
    logic [63:0]        sx2_reg;
    logic [63:0]        sy2_reg;
    logic [63:0]        sz2_reg;
    logic [63:0]        hx2_reg;
    logic [63:0]        hy2_reg;
    logic [31:0]        az_s2_reg;
    logic               dzneg_s2_reg;

    assign dx_neg = -dx_reg;
    assign dy_neg = -dy_reg;
    assign dz_neg = -dz_reg;
    assign ax     = dx_reg[32] ? dx_neg[31:0] : dx_reg[31:0];
    assign ay     = dy_reg[32] ? dy_neg[31:0] : dy_reg[31:0];
    assign az     = dz_reg[32] ? dz_neg[31:0] : dz_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx2_reg      <= {32'b0, ax} * {32'b0, ax};
            sy2_reg      <= {32'b0, ay} * {32'b0, ay};
            sz2_reg      <= {32'b0, az} * {32'b0, az};
            hx2_reg      <= {33'b0, ax[31:1]} * {33'b0, ax[31:1]};
            hy2_reg      <= {33'b0, ay[31:1]} * {33'b0, ay[31:1]};
            az_s2_reg    <= az;
            dzneg_s2_reg <= dz_reg[32];
        end
    end

    // Stage 3: horizontal sums, full and halved.
    logic [64:0] hs_reg;
    logic [63:0] hsh_reg;
    logic [63:0] sz2_s3_reg;
    logic [31:0] az_s3_reg;
    logic        dzneg_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hs_reg       <= {1'b0, sx2_reg} + {1'b0, sy2_reg};
            hsh_reg      <= hx2_reg + hy2_reg;
            sz2_s3_reg   <= sz2_reg;
            az_s3_reg    <= az_s2_reg;
            dzneg_s3_reg <= dzneg_s2_reg;
        end
    end

    // Stage 4: total sum with overflow check. A horizontal overflow switches the
    // pitch path to the halved components.
    logic [64:0]        ts_sum;
    logic [31:0]        pz_mag;
    logic signed [32:0] pz_pos;
    logic [63:0]        ts_reg;
    logic               sat_reg;
    logic [63:0]        hsel_reg;
    logic signed [32:0] pz_reg;

    assign ts_sum = {1'b0, hs_reg[63:0]} + {1'b0, sz2_s3_reg};
    assign pz_mag = hs_reg[64] ? {1'b0, az_s3_reg[31:1]} : az_s3_reg;
    assign pz_pos = {1'b0, pz_mag};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ts_reg   <= ts_sum[63:0];
            sat_reg  <= hs_reg[64] | ts_sum[64];
            hsel_reg <= hs_reg[64] ? hsh_reg : hs_reg[63:0];
            pz_reg   <= dzneg_s3_reg ? -pz_pos : pz_pos;
        end
    end

    // Square roots of the total, of the horizontal sum and of the camera pitch argument.
    logic [31:0] root_ts;
    logic [31:0] root_hs;
    logic [15:0] root_cam;

    awts_isqrt #(.IW(64)) u_sqrt_ts (
        .clk  (clk),
        .en   (en),
        .n_in (ts_reg),
        .root (root_ts)
    );

    awts_isqrt #(.IW(64)) u_sqrt_hs (
        .clk  (clk),
        .en   (en),
        .n_in (hsel_reg),
        .root (root_hs)
    );

    awts_isqrt #(.IW(32)) u_sqrt_cam (
        .clk  (clk),
        .en   (en),
        .n_in (carg_reg),
        .root (root_cam)
    );

    // Side paths aligned to the square root outputs.
    logic        sat_d;
    logic [32:0] pz_d;
    logic [15:0] lz_d;
    logic [15:0] root_cam_d;

    awts_delay #(.W(1), .DEPTH(ST_SQRT - ST_TS)) u_dly_sat (
        .clk (clk), .rst_n (rst_n), .en (en), .d (sat_reg), .q (sat_d)
    );

    awts_delay #(.W(33), .DEPTH(ST_SQRT - ST_TS)) u_dly_pz (
        .clk (clk), .rst_n (rst_n), .en (en), .d (pz_reg), .q (pz_d)
    );

    awts_delay #(.W(16), .DEPTH(ST_SQRT - ST_DIFF)) u_dly_lz (
        .clk (clk), .rst_n (rst_n), .en (en), .d (lz_reg), .q (lz_d)
    );

    awts_delay #(.W(16), .DEPTH(ST_SQRT - ST_DIFF - SQ32_L)) u_dly_rcam (
        .clk (clk), .rst_n (rst_n), .en (en), .d (root_cam), .q (root_cam_d)
    );

    // Angles.
    logic signed [CW-1:0] yaw_obj;
    logic signed [CW-1:0] yaw_cam;
    logic signed [CW-1:0] pitch_obj;
    logic signed [CW-1:0] pitch_cam;

    awts_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw_obj (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .x_in  ({{(CW-33){dx_reg[32]}}, dx_reg}),
        .y_in  ({{(CW-33){dy_reg[32]}}, dy_reg}),
        .z_out (yaw_obj)
    );

    awts_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .x_in  ({{(CW-16){lx_reg[15]}}, lx_reg}),
        .y_in  ({{(CW-16){ly_reg[15]}}, ly_reg}),
        .z_out (yaw_cam)
    );

    awts_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch_obj (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .x_in  ({{(CW-32){1'b0}}, root_hs}),
        .y_in  ({{(CW-33){pz_d[32]}}, pz_d}),
        .z_out (pitch_obj)
    );

    awts_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .x_in  ({{(CW-16){1'b0}}, root_cam_d}),
        .y_in  ({{(CW-16){lz_d[15]}}, lz_d}),
        .z_out (pitch_cam)
    );

    // Relative yaw, wrapped into minus pi to pi.
    logic signed [CW-1:0] yaw_diff;
    logic signed [CW-1:0] yaw_w1;
    logic signed [CW-1:0] rel_yaw_reg;
    logic [CW-1:0]        rel_yaw_d;

    always_comb
    begin
        yaw_diff = yaw_obj - yaw_cam;
        yaw_w1   = (yaw_diff > awts_pkg::Q30_PI) ? yaw_diff - awts_pkg::Q30_TWO_PI : yaw_diff;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_yaw_reg <= (yaw_w1 < -awts_pkg::Q30_PI) ? yaw_w1 + awts_pkg::Q30_TWO_PI : yaw_w1;
        end
    end

    awts_delay #(.W(CW), .DEPTH(ST_PROD - ST_RELY)) u_dly_yaw (
        .clk (clk), .rst_n (rst_n), .en (en), .d (rel_yaw_reg), .q (rel_yaw_d)
    );

    // Relative pitch, then scaled by the aspect ratio.
    logic signed [CW-1:0] rel_pitch_reg;
    logic signed [52:0]   prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_pitch_reg <= pitch_cam - pitch_obj;
            prod_reg      <= rel_pitch_reg * $signed({1'b0, aspect_ratio_reg});
        end
    end

    // Dividend magnitudes with half the divisor added for rounding.
    logic signed [CW-1:0] ry_s;
    logic signed [CW-1:0] ry_neg;
    logic [CW-1:0]        ry_mag;
    logic signed [52:0]   prod_neg;
    logic [52:0]          prod_mag;
    logic [DIV_W-1:0]     num_yaw_reg;
    logic [DIV_W-1:0]     num_pitch_reg;
    logic                 neg_yaw_reg;
    logic                 neg_pitch_reg;

    always_comb
    begin
        ry_s     = rel_yaw_d;
        ry_neg   = -ry_s;
        ry_mag   = ry_s[CW-1] ? ry_neg : ry_s;
        prod_neg = -prod_reg;
        prod_mag = prod_reg[52] ? prod_neg : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_yaw_reg   <= DIV_W'(ry_mag) + DIV_W'(fov_eff);
            num_pitch_reg <= prod_mag[DIV_W-1:0] + DIV_W'({fov_eff, 12'b0});
            neg_yaw_reg   <= ry_s[CW-1];
            neg_pitch_reg <= prod_reg[52];
        end
    end

    logic [DIV_W-1:0] q_yaw;
    logic [DIV_W-1:0] q_pitch;
    logic             neg_yaw_d;
    logic             neg_pitch_d;

    awts_div #(.NW(DIV_W), .DW(DEN_W)) u_div_yaw (
        .clk (clk),
        .en  (en),
        .num (num_yaw_reg),
        .den (den_yaw),
        .quo (q_yaw)
    );

    awts_div #(.NW(DIV_W), .DW(DEN_W)) u_div_pitch (
        .clk (clk),
        .en  (en),
        .num (num_pitch_reg),
        .den (den_pitch),
        .quo (q_pitch)
    );

    awts_delay #(.W(1), .DEPTH(ST_QUOT - ST_NUM)) u_dly_sy (
        .clk (clk), .rst_n (rst_n), .en (en), .d (neg_yaw_reg), .q (neg_yaw_d)
    );

    awts_delay #(.W(1), .DEPTH(ST_QUOT - ST_NUM)) u_dly_sp (
        .clk (clk), .rst_n (rst_n), .en (en), .d (neg_pitch_reg), .q (neg_pitch_d)
    );

    // Distance saturates when the sum of squares overflowed.
    logic [31:0] dist_c;
    logic [31:0] dist_d;

    assign dist_c = sat_d ? 32'hFFFF_FFFF : root_ts;

    awts_delay #(.W(32), .DEPTH(ST_QUOT - ST_SQRT)) u_dly_dist (
        .clk (clk), .rst_n (rst_n), .en (en), .d (dist_c), .q (dist_d)
    );

    // Valid flags follow the words through the pipeline.
    logic valid_d;

    awts_delay #(.W(1), .DEPTH(ST_QUOT)) u_dly_valid (
        .clk (clk), .rst_n (rst_n), .en (en), .d (in_valid), .q (valid_d)
    );

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -52'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [51:0] qy_s;
    logic signed [51:0] qp_s;
    logic signed [51:0] sx_wide;
    logic signed [51:0] sy_wide;

    always_comb
    begin
        qy_s    = {2'b0, q_yaw};
        qp_s    = {2'b0, q_pitch};
        sx_wide = neg_yaw_d ? 52'sd32768 + qy_s : 52'sd32768 - qy_s;
        sy_wide = neg_pitch_d ? 52'sd32768 - qp_s : 52'sd32768 + qp_s;
    end

    // Output register.
    logic signed [31:0] screen_x_reg;
    logic signed [31:0] screen_y_reg;
    logic [31:0]        distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            screen_x_reg <= sat32(sx_wide);
            screen_y_reg <= sat32(sy_wide);
            distance_reg <= dist_d;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;
    assign distance  = distance_reg;

endmodule

// File: rtl/awts_checker.sv
// Port-level assertions for the angular world-to-screen projection, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module awts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] screen_x,
    input logic signed [31:0] screen_y,
    input logic [31:0]        distance
);

    logic [95:0] out_word;

    assign out_word = {screen_x, screen_y, distance};

    // The input side is held back only by a result word that waits.
    `AWTS_ASSERT_ALWAYS(a_stall_src, in_stall == (out_valid && out_stall), "stray in_stall")

    // A held word keeps the input side stalled for as long as the output stall lasts.
    `AWTS_ASSERT_NEXT(a_stall_keep, out_valid && out_stall, in_stall == out_stall, "stall lost")

    // A stalled word keeps its payload.
    `AWTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_word), "held word changed")

endmodule

bind angular_world_to_screen awts_checker u_awts_checker (.*);
